@@ src/art_pkg.sv @@
package art_pkg;

  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned PageBytesDef    = 4096;

  localparam logic [1:0] CMD_MAP     = 2'd0;
  localparam logic [1:0] CMD_UNMAP   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;
  localparam logic [1:0] CMD_PROTECT = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_LEN  = 3'd1;
  localparam logic [2:0] ST_WRAP      = 3'd2;
  localparam logic [2:0] ST_OVERLAP   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_NO_OBJECT = 3'd6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] address;
    logic [63:0] span_bytes;
    logic [7:0]  protection;
    logic [7:0]  mapping_flags;
    logic [1:0]  inherit_mode;
    logic [15:0] object_handle;
    logic [63:0] object_base_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [63:0] found_base;
    logic [63:0] found_length;
    logic [7:0]  found_protection;
    logic [7:0]  found_flags;
    logic [1:0]  found_inherit;
    logic [15:0] found_object;
    logic [63:0] offset_in_object;
    logic [4:0]  live_regions;
  } rsp_t;

  // per-entry verdict from the shared compare unit
  typedef struct packed {
    logic overlap;
    logic base_eq;
    logic contains;
  } cmp_t;

endpackage

@@ src/art_if.sv @@
interface art_req_if;
  import art_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface art_rsp_if;
  import art_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/art_cmp.sv @@
// Shared compare unit: one table entry against the current request.
module art_cmp (
  input  logic [63:0]      base_i,
  input  logic [63:0]      end_i,
  input  logic [63:0]      addr_i,
  input  logic [63:0]      ebase_i,
  input  logic [63:0]      elen_i,
  output art_pkg::cmp_t    res_o
);
  import art_pkg::*;
  logic [64:0] eend;
  logic [63:0] diff;
  always_comb begin
    eend = {1'b0, ebase_i} + {1'b0, elen_i};
    diff = addr_i - ebase_i;
    res_o.overlap  = !((end_i <= ebase_i) || ({1'b0, base_i} >= {1'b0, eend[63:0]}));
    res_o.base_eq  = (ebase_i == base_i);
    res_o.contains = (addr_i >= ebase_i) && (diff < elen_i);
  end
endmodule

@@ src/address_region_table.sv @@
// Bounded table of non-overlapping page-aligned address regions. One command
// word in gives one result word out. A setup state (PREP) does the page
// rounding and wrap checks. The scan state (SCAN) then steps through every
// slot; the region memory read is registered, and the single shared compare
// unit works one slot behind the read address. The READ state reads the
// chosen slot, and the DONE state builds the result. A map that fails its
// length checks leaves the scan at once and goes to DONE without the READ
// state. The block takes no new command until the result is taken. The
// result sits in an output register. Between two commands the block passes
// through the output state OUT and the IDLE state that takes the next word.
// No clearing pass runs after reset, because the data of a slot is used only
// while the slot is marked valid.
module address_region_table #(
  parameter int unsigned TABLE_ENTRIES = art_pkg::TableEntriesDef,
  parameter int unsigned PAGE_BYTES    = art_pkg::PageBytesDef
) (
  input logic clk_i,
  input logic rst_ni,
  art_req_if.sink   req,
  art_rsp_if.source rsp
);
  import art_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned PW = $clog2(PAGE_BYTES);
  localparam logic [IW:0] LAST = (IW+1)'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  req_t       req_q;
  logic [63:0] base_q, len_q, end_q;
  logic [IW:0] idx_q;
  logic        hit_q, free_q, ovl_q;
  logic [IW-1:0] hit_idx_q, free_idx_q;
  logic [2:0]  pre_st_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [8:0]  total_q;
  rsp_t        rsp_q;
  rsp_t        rsp_d;

  // region memory
  logic [63:0] m_base [TABLE_ENTRIES];
  logic [63:0] m_len  [TABLE_ENTRIES];
  logic [7:0]  m_prot [TABLE_ENTRIES];
  logic [7:0]  m_flag [TABLE_ENTRIES];
  logic [1:0]  m_inh  [TABLE_ENTRIES];
  logic [15:0] m_obj  [TABLE_ENTRIES];
  logic [63:0] m_off  [TABLE_ENTRIES];
  logic [63:0] rd_base_q, rd_len_q, rd_off_q;
  logic [7:0]  rd_prot_q, rd_flag_q;
  logic [1:0]  rd_inh_q;
  logic [15:0] rd_obj_q;
  logic [IW-1:0] rd_addr;
  logic          rd_scan_q;  // read data belongs to scan slot idx_q-1
  logic [IW-1:0] rd_idx_q;

  cmp_t cmp;

  art_cmp u_cmp (
    .base_i (base_q),
    .end_i  (end_q),
    .addr_i (req_q.address),
    .ebase_i(rd_base_q),
    .elen_i (rd_len_q),
    .res_o  (cmp)
  );

  // page rounding, captured in PREP
  logic [63:0] abase, rem, rnd;
  logic [64:0] rlen, rend;
  always_comb begin
    abase = {req_q.address[63:PW], {PW{1'b0}}};
    rem   = {{(64-PW){1'b0}}, req_q.span_bytes[PW-1:0]};
    rnd   = (rem == '0) ? 64'd0 : (64'(PAGE_BYTES) - rem);
    rlen  = {1'b0, req_q.span_bytes} + {1'b0, rnd};
    rend  = {1'b0, abase} + {1'b0, rlen[63:0]};
  end

  assign rd_addr = (state_q == S_SCAN) ? idx_q[IW-1:0] : hit_idx_q;

  logic wr_map, wr_prot;
  assign wr_map  = (state_q == S_DONE) && (req_q.cmd == CMD_MAP) && (pre_st_q == ST_OK)
                   && !ovl_q && free_q;
  assign wr_prot = (state_q == S_DONE) && (req_q.cmd == CMD_PROTECT) && hit_q;

  always_ff @(posedge clk_i) begin
    rd_base_q <= m_base[rd_addr];
    rd_len_q  <= m_len[rd_addr];
    rd_prot_q <= m_prot[rd_addr];
    rd_flag_q <= m_flag[rd_addr];
    rd_inh_q  <= m_inh[rd_addr];
    rd_obj_q  <= m_obj[rd_addr];
    rd_off_q  <= m_off[rd_addr];
    if (wr_map) begin
      m_base[free_idx_q] <= base_q;
      m_len[free_idx_q]  <= len_q;
      m_prot[free_idx_q] <= req_q.protection;
      m_flag[free_idx_q] <= req_q.mapping_flags;
      m_inh[free_idx_q]  <= req_q.inherit_mode;
      m_obj[free_idx_q]  <= req_q.object_handle;
      m_off[free_idx_q]  <= req_q.object_base_offset;
    end else if (wr_prot) begin
      m_prot[hit_idx_q] <= req_q.protection;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (req.valid) state_d = S_PREP;
      S_PREP: state_d = S_SCAN;
      S_SCAN: begin
        if (req_q.cmd == CMD_MAP && pre_st_q != ST_OK) state_d = S_DONE;
        else if (idx_q == LAST + 1'b1) state_d = S_READ;
      end
      S_READ: state_d = S_DONE;
      S_DONE: state_d = S_OUT;
      S_OUT:  if (rsp.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = (state_q == S_OUT);
  assign rsp.data  = rsp_q;

  logic sv;  // slot under test was valid
  assign sv = rd_scan_q && valid_q[rd_idx_q];

  // result word, registered in DONE
  always_comb begin
    rsp_d = '0;
    rsp_d.live_regions = 5'(total_q);
    case (req_q.cmd)
      CMD_MAP: begin
        if (pre_st_q != ST_OK) rsp_d.status = pre_st_q;
        else if (ovl_q) rsp_d.status = ST_OVERLAP;
        else if (!free_q) rsp_d.status = ST_FULL;
        else begin
          rsp_d.slot = 4'(free_idx_q);
          rsp_d.found_base = base_q;
          rsp_d.found_length = len_q;
          rsp_d.found_protection = req_q.protection;
          rsp_d.found_flags = req_q.mapping_flags;
          rsp_d.found_inherit = req_q.inherit_mode;
          rsp_d.found_object = req_q.object_handle;
          rsp_d.live_regions = 5'(total_q + 9'd1);
        end
      end
      default: begin
        if (!hit_q) rsp_d.status = ST_NOT_FOUND;
        else begin
          rsp_d.slot = 4'(hit_idx_q);
          rsp_d.found_base = rd_base_q;
          rsp_d.found_length = rd_len_q;
          rsp_d.found_protection = (req_q.cmd == CMD_PROTECT) ? req_q.protection
                                                              : rd_prot_q;
          rsp_d.found_flags = rd_flag_q;
          rsp_d.found_inherit = rd_inh_q;
          rsp_d.found_object = rd_obj_q;
          if (req_q.cmd == CMD_UNMAP) rsp_d.live_regions = 5'(total_q - 9'd1);
          if (req_q.cmd == CMD_LOOKUP) begin
            if (rd_obj_q == '0) rsp_d.status = ST_NO_OBJECT;
            else rsp_d.offset_in_object = rd_off_q + (req_q.address - rd_base_q);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      if (wr_map) begin
        valid_q[free_idx_q] <= 1'b1;
        total_q <= total_q + 9'd1;
      end
      if ((state_q == S_DONE) && (req_q.cmd == CMD_UNMAP) && hit_q) begin
        valid_q[hit_idx_q] <= 1'b0;
        total_q <= total_q - 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req.valid) req_q <= req.data;
    case (state_q)
      S_PREP: begin
        base_q <= abase;
        len_q  <= rlen[63:0];
        end_q  <= rend[63:0];
        idx_q  <= '0;
        rd_scan_q <= 1'b0;
        hit_q <= 1'b0; free_q <= 1'b0; ovl_q <= 1'b0;
        hit_idx_q <= '0; free_idx_q <= '0;
        if (req_q.cmd != CMD_MAP) pre_st_q <= ST_OK;
        else if (req_q.span_bytes == '0) pre_st_q <= ST_ZERO_LEN;
        else if (rlen[64] || rend[64] || rend[63:0] == '0) pre_st_q <= ST_WRAP;
        else pre_st_q <= ST_OK;
      end
      S_SCAN: begin
        idx_q <= idx_q + 1'b1;
        rd_idx_q <= idx_q[IW-1:0];
        rd_scan_q <= 1'b1;
        if (rd_scan_q) begin
          if (sv) begin
            if (cmp.overlap) ovl_q <= 1'b1;
            if (!hit_q && ((req_q.cmd == CMD_UNMAP) ? cmp.base_eq : cmp.contains)) begin
              hit_q <= 1'b1;
              hit_idx_q <= rd_idx_q;
            end
          end else if (!free_q) begin
            free_q <= 1'b1;
            free_idx_q <= rd_idx_q;
          end
        end
      end
      S_DONE: begin
        rsp_q <= rsp_d;
      end
      default: ;
    endcase
  end

  // count never exceeds the table size
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= 9'(TABLE_ENTRIES)) else $error("region count overflow");
  // the valid map changes only in the commit cycle
  a_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DONE) |=> $stable(valid_q)) else $error("valid map changed outside commit");
  // result follows the commit cycle
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> rsp.valid) else $error("result not presented");

endmodule
